// File: sv/ipv4hc_pkg.sv
// shared types, constants and verdict codes of the ipv4 receive header check
`default_nettype none

package ipv4hc_pkg;

    // default width of the buffer byte counter
    localparam int LenBitsDefault = 16;

    // header field constants
    localparam int IpVersion4      = 4;
    localparam int MinIhl          = 5;
    localparam int ProtoIcmp       = 1;
    localparam int ProtoUdp        = 17;
    localparam int IpHdrLenPerByte = 4;
    localparam int MinHdrBytes     = 20;
    localparam int HdrCaptureBytes = 60;

    // verdict codes
    typedef enum logic [2:0] {
        V_DELIVER  = 3'd0,
        V_SHORT    = 3'd1,
        V_VERSION  = 3'd2,
        V_LENGTH   = 3'd3,
        V_IHL      = 3'd4,
        V_CHECKSUM = 3'd5,
        V_NOT_OURS = 3'd6,
        V_PROTO    = 3'd7
    } t_verdict;

    // everything captured from one packet, handed from accumulator to evaluator
    typedef struct packed {
        logic        over;
        logic [15:0] len;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [15:0] stored_checksum;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [20:0] word_sum;
    } t_snap;

endpackage

`default_nettype wire

// File: sv/ipv4hc_accum.sv
// per-byte accumulator: byte counter, header field capture, header word sum
`default_nettype none

module ipv4hc_accum #(
    parameter int LEN_BITS = ipv4hc_pkg::LenBitsDefault
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    output logic                   o_snap_valid,
    input  wire logic              i_snap_ready,
    output ipv4hc_pkg::t_snap      o_snap
);

    logic [LEN_BITS-1:0] r_byte_count, n_byte_count;
    logic [7:0]          r_version_ihl, n_version_ihl;
    logic [15:0]         r_total_length, n_total_length;
    logic [7:0]          r_proto_field, n_proto_field;
    logic [15:0]         r_stored_checksum, n_stored_checksum;
    logic [31:0]         r_src_addr, n_src_addr;
    logic [31:0]         r_dst_addr, n_dst_addr;
    logic [20:0]         r_word_sum, n_word_sum;
    logic [7:0]          r_high_byte_hold, n_high_byte_hold;
    logic                r_snap_valid;
    ipv4hc_pkg::t_snap   r_snap;

    logic                accept;
    logic                over;
    logic                in_zone;
    logic [5:0]          idx;
    logic [5:0]          hdr_lim;

    assign o_ready = !r_snap_valid || i_snap_ready;
    assign accept  = i_valid && o_ready;

    // next state for one byte
    always_comb begin
        n_version_ihl     = r_version_ihl;
        n_total_length    = r_total_length;
        n_proto_field     = r_proto_field;
        n_stored_checksum = r_stored_checksum;
        n_src_addr        = r_src_addr;
        n_dst_addr        = r_dst_addr;
        n_word_sum        = r_word_sum;
        n_high_byte_hold  = r_high_byte_hold;

        over    = (r_byte_count == {LEN_BITS{1'b1}});
        in_zone = (r_byte_count < LEN_BITS'(ipv4hc_pkg::HdrCaptureBytes));
        idx     = r_byte_count[5:0];
        // odd bytes only add once the ihl byte is in, so the held value serves
        hdr_lim = 6'(r_version_ihl[3:0] * ipv4hc_pkg::IpHdrLenPerByte);

        n_byte_count = over ? r_byte_count : r_byte_count + LEN_BITS'(1);

        if (in_zone) begin
            // field capture by byte position
            unique case (idx)
                6'd0: n_version_ihl = i_data_byte;
                6'd2: n_total_length[15:8] = i_data_byte;
                6'd3: n_total_length[7:0] = i_data_byte;
                6'd9: n_proto_field = i_data_byte;
                6'd10: n_stored_checksum[15:8] = i_data_byte;
                6'd11: n_stored_checksum[7:0] = i_data_byte;
                6'd12, 6'd13, 6'd14, 6'd15: n_src_addr = {r_src_addr[23:0], i_data_byte};
                6'd16, 6'd17, 6'd18, 6'd19: n_dst_addr = {r_dst_addr[23:0], i_data_byte};
                default: ;
            endcase

            // header word sum, checksum word skipped
            if (!idx[0]) begin
                n_high_byte_hold = i_data_byte;
            end else if (idx < hdr_lim && idx != 6'd11) begin
                n_word_sum = r_word_sum + {5'b0, r_high_byte_hold, i_data_byte};
            end
        end
    end

    // packet state, cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_byte)) begin
            r_byte_count      <= '0;
            r_version_ihl     <= '0;
            r_total_length    <= '0;
            r_proto_field     <= '0;
            r_stored_checksum <= '0;
            r_src_addr        <= '0;
            r_dst_addr        <= '0;
            r_word_sum        <= '0;
            r_high_byte_hold  <= '0;
        end else if (accept) begin
            r_byte_count      <= n_byte_count;
            r_version_ihl     <= n_version_ihl;
            r_total_length    <= n_total_length;
            r_proto_field     <= n_proto_field;
            r_stored_checksum <= n_stored_checksum;
            r_src_addr        <= n_src_addr;
            r_dst_addr        <= n_dst_addr;
            r_word_sum        <= n_word_sum;
            r_high_byte_hold  <= n_high_byte_hold;
        end
    end

    // snapshot stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (accept && i_last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_ready) begin
            r_snap_valid <= 1'b0;
        end
    end

    // snapshot payload, loaded with the last beat included
    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_snap.over            <= over;
            r_snap.len             <= 16'(n_byte_count);
            r_snap.version_ihl     <= n_version_ihl;
            r_snap.total_length    <= n_total_length;
            r_snap.protocol        <= n_proto_field;
            r_snap.stored_checksum <= n_stored_checksum;
            r_snap.src_addr        <= n_src_addr;
            r_snap.dst_addr        <= n_dst_addr;
            r_snap.word_sum        <= n_word_sum;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

// File: sv/ipv4hc_eval.sv
// verdict evaluation and result register, with the local address register
`default_nettype none

module ipv4hc_eval (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [31:0]       i_cfg_wr_data,
    input  wire logic              i_snap_valid,
    output logic                   o_snap_ready,
    input  wire ipv4hc_pkg::t_snap i_snap,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [2:0]             o_verdict,
    output logic [7:0]             o_protocol,
    output logic [31:0]            o_source_ip,
    output logic [5:0]             o_header_bytes,
    output logic [15:0]            o_payload_len,
    output logic [15:0]            o_padding_len
);

    logic [31:0]          r_local_ip;
    logic                 r_valid;
    ipv4hc_pkg::t_verdict r_verdict, n_verdict;
    logic [7:0]           r_protocol;
    logic [31:0]          r_source_ip;
    logic [5:0]           r_header_bytes, n_header_bytes;
    logic [15:0]          r_payload_len, n_payload_len;
    logic [15:0]          r_padding_len, n_padding_len;

    logic [15:0]          hdr16;
    logic [16:0]          fold1;
    logic [15:0]          fold2;
    logic [15:0]          calc_csum;
    logic                 load;

    assign o_snap_ready = !r_valid || i_ready;
    assign load         = i_snap_valid && o_snap_ready;

    // local address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
        end else if (i_cfg_wr_en) begin
            r_local_ip <= i_cfg_wr_data;
        end
    end

    // checksum fold, lengths and verdict priority
    always_comb begin
        n_header_bytes = 6'(i_snap.version_ihl[3:0] * ipv4hc_pkg::IpHdrLenPerByte);
        hdr16          = {10'b0, n_header_bytes};
        fold1          = {1'b0, i_snap.word_sum[15:0]} + {12'b0, i_snap.word_sum[20:16]};
        fold2          = fold1[15:0] + {15'b0, fold1[16]};
        calc_csum      = ~fold2;

        n_payload_len = (i_snap.total_length >= hdr16) ? i_snap.total_length - hdr16 : '0;
        n_padding_len = (i_snap.len >= i_snap.total_length)
                      ? i_snap.len - i_snap.total_length : '0;

        priority if (i_snap.len < 16'(ipv4hc_pkg::MinHdrBytes)) begin
            n_verdict = ipv4hc_pkg::V_SHORT;
        end else if (i_snap.version_ihl[7:4] != 4'(ipv4hc_pkg::IpVersion4)) begin
            n_verdict = ipv4hc_pkg::V_VERSION;
        end else if (i_snap.total_length > i_snap.len || i_snap.over) begin
            n_verdict = ipv4hc_pkg::V_LENGTH;
        end else if (i_snap.version_ihl[3:0] < 4'(ipv4hc_pkg::MinIhl)) begin
            n_verdict = ipv4hc_pkg::V_IHL;
        end else if (hdr16 > i_snap.len || i_snap.total_length < hdr16) begin
            n_verdict = ipv4hc_pkg::V_LENGTH;
        end else if (calc_csum != i_snap.stored_checksum) begin
            n_verdict = ipv4hc_pkg::V_CHECKSUM;
        end else if (i_snap.dst_addr != r_local_ip) begin
            n_verdict = ipv4hc_pkg::V_NOT_OURS;
        end else if (i_snap.protocol != 8'(ipv4hc_pkg::ProtoIcmp)
                  && i_snap.protocol != 8'(ipv4hc_pkg::ProtoUdp)) begin
            n_verdict = ipv4hc_pkg::V_PROTO;
        end else begin
            n_verdict = ipv4hc_pkg::V_DELIVER;
        end
    end

    // result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_verdict      <= n_verdict;
            r_protocol     <= i_snap.protocol;
            r_source_ip    <= i_snap.src_addr;
            r_header_bytes <= n_header_bytes;
            r_payload_len  <= n_payload_len;
            r_padding_len  <= n_padding_len;
        end
    end

    assign o_valid        = r_valid;
    assign o_verdict      = r_verdict;
    assign o_protocol     = r_protocol;
    assign o_source_ip    = r_source_ip;
    assign o_header_bytes = r_header_bytes;
    assign o_payload_len  = r_payload_len;
    assign o_padding_len  = r_padding_len;

endmodule

`default_nettype wire

// File: sv/ipv4_rx_header_check_core.sv
// top level of the ipv4 receive header check
`default_nettype none

// Checks received IPv4 packets that arrive one byte per beat, header first,
// with a mark on the last byte of the buffer. One byte is taken every clock while
// ready is high; the byte counter and header capture registers update in the cycle
// the beat is accepted. The last byte is copied into a snapshot register at the edge
// that accepts it, and its single result beat is valid from the next edge when the
// result register is free. The beat holds the verdict (first failing check wins:
// short, version, length, ihl, checksum, address, protocol), the protocol, source
// address, header length, payload length and padding length. The snapshot register
// between the capture logic and the result register lets the next packet stream in
// while a result waits; input ready drops only when a snapshot is held and the
// result beat in front of it is not taken. The user must write the local address
// through the configuration port only while the block is idle; the block does not
// enforce it. LEN_BITS sets the width of the saturating byte counter; a buffer
// reaching its ceiling is reported as a length error.
module ipv4_rx_header_check_core #(
    parameter int LEN_BITS = ipv4hc_pkg::LenBitsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_verdict,
    output logic [7:0]       o_protocol,
    output logic [31:0]      o_source_ip,
    output logic [5:0]       o_header_bytes,
    output logic [15:0]      o_payload_len,
    output logic [15:0]      o_padding_len
);

    logic              snap_valid;
    logic              snap_ready;
    ipv4hc_pkg::t_snap snap;

    // byte capture and header sum
    ipv4hc_accum #(
        .LEN_BITS (LEN_BITS)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    // verdict and result register
    ipv4hc_eval u_eval (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_snap_valid   (snap_valid),
        .o_snap_ready   (snap_ready),
        .i_snap         (snap),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_verdict      (o_verdict),
        .o_protocol     (o_protocol),
        .o_source_ip    (o_source_ip),
        .o_header_bytes (o_header_bytes),
        .o_payload_len  (o_payload_len),
        .o_padding_len  (o_padding_len)
    );

endmodule

`default_nettype wire

// File: sv/ipv4hc_checker.sv
// port-level checker for the ipv4 receive header check, with its bind
`default_nettype none

module ipv4hc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [2:0]  o_verdict,
    input wire logic [7:0]  o_protocol,
    input wire logic [5:0]  o_header_bytes
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_verdict))
        else $error("result beat changed while stalled");

    // input only backs up behind a stalled result
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a waiting result");

    // header length is a whole number of words
    a_hdr_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_header_bytes[1:0] == 2'b00)
        else $error("header length not a multiple of four");

    // a delivered packet has a full header and a known protocol
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_verdict == ipv4hc_pkg::V_DELIVER |->
            o_header_bytes >= 6'(ipv4hc_pkg::MinHdrBytes)
            && (o_protocol == 8'(ipv4hc_pkg::ProtoIcmp)
                || o_protocol == 8'(ipv4hc_pkg::ProtoUdp)))
        else $error("delivered packet fails header checks");

    // ihl verdict only for a header under minimum size
    a_ihl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_verdict == ipv4hc_pkg::V_IHL |->
            o_header_bytes < 6'(ipv4hc_pkg::MinHdrBytes))
        else $error("ihl verdict with a full-size header");

endmodule

bind ipv4_rx_header_check_core ipv4hc_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_verdict      (o_verdict),
    .o_protocol     (o_protocol),
    .o_header_bytes (o_header_bytes)
);

`default_nettype wire
